/* hdl/gregorian_date_range_counter_top_macros.svh */
// Assertion macros for the Gregorian date range counter.
`ifndef GREGORIAN_DATE_RANGE_COUNTER_TOP_MACROS_SVH
`define GREGORIAN_DATE_RANGE_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GDRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gdrc assertion failed");

// Next-cycle implication.
`define GDRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gdrc assertion failed");

`endif

/* hdl/gdrc_pkg.sv */
// Types, constants and calendar tables shared by the date range counter.
package gdrc_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned DnW    = YearW + 9;   // serial day number width
  localparam int unsigned CountW = 25;
  localparam int unsigned QW     = YearW - 6;   // width of year / 100

  // year / 100 by reciprocal multiply: exact for every YearW-bit year
  localparam int unsigned Div100Shift = YearW + 7;
  localparam int unsigned Div100MulW  = YearW + 1;
  localparam logic [Div100MulW-1:0] Div100Mult =
    Div100MulW'(((64'd1 << Div100Shift) + 64'd99) / 64'd100);

  typedef enum logic [1:0] {
    OrdEqual   = 2'd0,
    OrdEarlier = 2'd1,
    OrdLater   = 2'd2,
    OrdInvalid = 2'd3
  } ord_e;

  typedef struct packed {
    logic [YearW-1:0] first_year;
    logic [7:0]       first_month;
    logic [7:0]       first_day;
    logic [YearW-1:0] last_year;
    logic [7:0]       last_month;
    logic [7:0]       last_day;
  } date_pair_t;

  typedef struct packed {
    logic              start_ok;
    logic              end_ok;
    logic              start_leap;
    logic              end_leap;
    logic [4:0]        start_month_length;
    logic [8:0]        start_year_day;
    logic [8:0]        end_year_day;
    ord_e              order;
    logic              range_ok;
    logic [CountW-1:0] day_count;
  } result_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [7:0]       month;
    logic [7:0]       day;
    logic             ok;
    logic             leap;
    logic [4:0]       mlen;
    logic [8:0]       yday;
    logic [DnW-1:0]   dnum;
  } lane_t;

  // idx is month - 1
  function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] n;
    case (idx)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      4'd11:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

/* hdl/gdrc_lane.sv */
// One date lane: leap flag, validity, day of year and serial day number.
module gdrc_lane (
  input  logic                          clk_i,
  input  logic [gdrc_pkg::YearW-1:0]    year_i,
  input  logic [7:0]                    month_i,
  input  logic [7:0]                    day_i,
  output gdrc_pkg::lane_t               lane_o
);

  localparam int unsigned YW  = gdrc_pkg::YearW;
  localparam int unsigned QW  = gdrc_pkg::QW;
  localparam int unsigned DnW = gdrc_pkg::DnW;
  localparam int unsigned PW  = YW + gdrc_pkg::Div100MulW;

  // stage 1: captured date
  logic [YW-1:0] y1_q;
  logic [7:0]    m1_q, d1_q;
  // stage 2: year / 100
  logic [YW-1:0] y2_q;
  logic [7:0]    m2_q, d2_q;
  logic [QW-1:0] qy2_q;
  // stage 3: calendar fields and partial day number terms
  logic [YW-1:0]  y3_q, pq4_q;
  logic [7:0]     m3_q, d3_q;
  logic           ok3_q, leap3_q;
  logic [4:0]     mlen3_q;
  logic [8:0]     yd3_q;
  logic [DnW-1:0] p365_q;
  logic [QW-1:0]  q100_q;
  gdrc_pkg::lane_t lane_q;

  logic [PW-1:0]  div_prod;
  logic [QW-1:0]  qy_d;
  logic [YW-1:0]  hund, p;
  logic           rzero, leap_d, mvalid, dok;
  logic [3:0]     idx;
  logic [4:0]     mlen_d;
  logic [8:0]     yd_d;
  logic [DnW-1:0] p365_d, dn_d;

  assign div_prod = PW'(y1_q) * PW'(gdrc_pkg::Div100Mult);
  assign qy_d     = div_prod[gdrc_pkg::Div100Shift +: QW];

  assign hund   = YW'(qy2_q) * YW'(7'd100);
  assign rzero  = (y2_q == hund);
  assign leap_d = (y2_q[1:0] == 2'b00) && (!rzero || (qy2_q[1:0] == 2'b00));
  assign mvalid = (m2_q >= 8'd1) && (m2_q <= 8'd12);
  assign idx    = m2_q[3:0] - 4'd1;
  assign mlen_d = ((y2_q != '0) && mvalid) ? gdrc_pkg::month_days(idx, leap_d) : 5'd0;
  assign dok    = (d2_q != 8'd0) && (d2_q <= {3'b000, mlen_d});
  assign yd_d   = dok ? (gdrc_pkg::days_before(idx) + 9'(d2_q)
                         + 9'((m2_q > 8'd2) && leap_d)) : 9'd0;
  assign p      = y2_q - YW'(1);
  assign p365_d = DnW'(p) * DnW'(9'd365);

  // (y-1)/100 is y/100 less one exactly when y is a multiple of 100
  assign dn_d = p365_q + DnW'(pq4_q) - DnW'(q100_q) + DnW'(q100_q >> 2) + DnW'(yd3_q);

  always_ff @(posedge clk_i) begin
    y1_q    <= year_i;
    m1_q    <= month_i;
    d1_q    <= day_i;

    y2_q    <= y1_q;
    m2_q    <= m1_q;
    d2_q    <= d1_q;
    qy2_q   <= qy_d;

    y3_q    <= y2_q;
    m3_q    <= m2_q;
    d3_q    <= d2_q;
    ok3_q   <= dok;
    leap3_q <= leap_d;
    mlen3_q <= mlen_d;
    yd3_q   <= yd_d;
    p365_q  <= p365_d;
    pq4_q   <= p >> 2;
    q100_q  <= qy2_q - QW'(rzero);

    lane_q.year  <= y3_q;
    lane_q.month <= m3_q;
    lane_q.day   <= d3_q;
    lane_q.ok    <= ok3_q;
    lane_q.leap  <= leap3_q;
    lane_q.mlen  <= mlen3_q;
    lane_q.yday  <= yd3_q;
    lane_q.dnum  <= dn_d;
  end

  assign lane_o = lane_q;

endmodule

/* hdl/gdrc_merge.sv */
// Merge stage: orders the two dates and forms the inclusive day count.
module gdrc_merge (
  input  logic              clk_i,
  input  gdrc_pkg::lane_t   start_lane_i,
  input  gdrc_pkg::lane_t   end_lane_i,
  output gdrc_pkg::result_t result_o
);

  localparam int unsigned KeyW = gdrc_pkg::YearW + 16;

  logic [KeyW-1:0]         key_s, key_e;
  gdrc_pkg::ord_e          ord_d;
  logic                    rok_d;
  logic [gdrc_pkg::DnW-1:0] diff;
  gdrc_pkg::result_t       result_q;

  assign key_s = {start_lane_i.year, start_lane_i.month, start_lane_i.day};
  assign key_e = {end_lane_i.year, end_lane_i.month, end_lane_i.day};

  always_comb begin
    if (!(start_lane_i.ok && end_lane_i.ok)) begin
      ord_d = gdrc_pkg::OrdInvalid;
    end else if (key_s == key_e) begin
      ord_d = gdrc_pkg::OrdEqual;
    end else if (key_s < key_e) begin
      ord_d = gdrc_pkg::OrdEarlier;
    end else begin
      ord_d = gdrc_pkg::OrdLater;
    end
  end

  assign rok_d = (ord_d == gdrc_pkg::OrdEqual) || (ord_d == gdrc_pkg::OrdEarlier);
  assign diff  = end_lane_i.dnum - start_lane_i.dnum + gdrc_pkg::DnW'(1);

  always_ff @(posedge clk_i) begin
    result_q.start_ok           <= start_lane_i.ok;
    result_q.end_ok             <= end_lane_i.ok;
    result_q.start_leap         <= start_lane_i.leap;
    result_q.end_leap           <= end_lane_i.leap;
    result_q.start_month_length <= start_lane_i.mlen;
    result_q.start_year_day     <= start_lane_i.yday;
    result_q.end_year_day       <= end_lane_i.yday;
    result_q.order              <= ord_d;
    result_q.range_ok           <= rok_d;
    result_q.day_count          <= rok_d ? gdrc_pkg::CountW'(diff) : '0;
  end

  assign result_o = result_q;

endmodule

/* hdl/gregorian_date_range_counter_top.sv */
// Top level of the Gregorian date range counter: two date lanes and a merge stage.
//
// Usage:
//   Drive a start/end date pair on data_i and raise start. The pair is
//   transferred at a rising edge where start is high and busy is low.
//   busy is high only during reset and up to the first edge after it; from
//   then on a new pair can be transferred every cycle.
//   Each transfer yields exactly one result on result_o, marked by done_o
//   for a single cycle. done_o rises together with the result, which
//   passes four register stages in each lane (capture, divide-by-100
//   multiply, calendar fields with the 365x product, day number sum)
//   and one in the merge stage (order compare and subtract).
//   Throughput is one pair per cycle, fixed by that pipeline.
//   The receiver cannot stall: a result is presented for one cycle only
//   and must be taken then.
//   Reset (rst_ni low, asynchronous) empties the valid pipeline, so no
//   strobe follows reset; pairs in flight are dropped.
//   Invalid dates give zero year days, order code invalid, range_ok low
//   and a zero count; equal dates count one day.
module gregorian_date_range_counter_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  gdrc_pkg::date_pair_t data_i,
  output logic                 done_o,
  output gdrc_pkg::result_t    result_o
);

  `include "gregorian_date_range_counter_top_macros.svh"

  localparam int unsigned Depth = 4;   // lane pipeline depth

  logic             busy_q;
  logic [Depth-1:0] vld_q;
  logic             done_q;
  logic             xfer;

  gdrc_pkg::lane_t start_lane, end_lane;

  assign xfer = start && !busy_q;

  // start date lane
  gdrc_lane u_lane_start (
    .clk_i   (clk_i),
    .year_i  (data_i.first_year),
    .month_i (data_i.first_month),
    .day_i   (data_i.first_day),
    .lane_o  (start_lane)
  );

  // end date lane
  gdrc_lane u_lane_end (
    .clk_i   (clk_i),
    .year_i  (data_i.last_year),
    .month_i (data_i.last_month),
    .day_i   (data_i.last_day),
    .lane_o  (end_lane)
  );

  gdrc_merge u_merge (
    .clk_i        (clk_i),
    .start_lane_i (start_lane),
    .end_lane_i   (end_lane),
    .result_o     (result_o)
  );

  // valid bits follow each transfer through the lanes and the merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[Depth-2:0], xfer};
      done_q <= vld_q[Depth-1];
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

  // every transfer is followed by its done_o strobe
  `GDRC_ASSERT_IMP(a_latency, xfer, ##5 done_o)
  // range flag agrees with the order code
  `GDRC_ASSERT_IMP(a_range_order, done_o, result_o.range_ok ==
    ((result_o.order == gdrc_pkg::OrdEqual) || (result_o.order == gdrc_pkg::OrdEarlier)))
  // count is zero outside a valid range
  `GDRC_ASSERT_IMP(a_count_zero, done_o && !result_o.range_ok, result_o.day_count == '0)
  // equal dates span one day
  `GDRC_ASSERT_IMP(a_equal_one, done_o && (result_o.order == gdrc_pkg::OrdEqual),
    result_o.day_count == gdrc_pkg::CountW'(1))
  // a valid start date has a nonzero day of year and month length
  `GDRC_ASSERT_IMP(a_start_yday, done_o && result_o.start_ok,
    (result_o.start_year_day != '0) && (result_o.start_month_length != '0))
  // nothing is strobed right after reset release
  `GDRC_ASSERT_NXT(a_no_spurious, busy_q, !done_o)

endmodule
